// ===== design/balanced_gray_code_pixel_decoder_assert.svh =====
// Assertion helpers for the pixel decoder.
`ifndef BALANCED_GRAY_CODE_PIXEL_DECODER_ASSERT_SVH
`define BALANCED_GRAY_CODE_PIXEL_DECODER_ASSERT_SVH

// Property holds at every clock edge outside reset.
`define BGC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition never holds outside reset.
`define BGC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`BGC_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ===== design/bgc_pkg.sv =====
`default_nettype none
package bgc_pkg;

	localparam int MAX_AXIS_BITS = 16;
	localparam int SAMPLE_BITS   = 8;
	localparam int AXIS_W        = 5;
	localparam int CNT_W         = 6;
	localparam int CODE_W        = 32;
	localparam int SUM_W         = 14;
	localparam int DIM_W         = 17;
	localparam int COORD_W       = MAX_AXIS_BITS;
	localparam int IDX_W         = 32;
	localparam int MEAN_W        = 8;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = DIM_W;
	localparam int PROD_W        = COORD_W + DIM_W;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	localparam int DIV_STEPS = SUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	localparam logic [CFG_IDX_W-1:0] CFG_BITS_X      = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_BITS_Y      = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_PROJ_WIDTH  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_PROJ_HEIGHT = CFG_IDX_W'(3);

	typedef struct packed {
		logic [AXIS_W-1:0] bits_x;
		logic [AXIS_W-1:0] bits_y;
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
	} cfg_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [SUM_W-1:0]  sum;
		logic [CNT_W-1:0]  used;
		logic              wrong;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MULT,
		ST_DIV,
		ST_FINISH
	} state_t;

	function automatic logic [AXIS_W-1:0] axis_bits(logic [AXIS_W-1:0] v);
		return (v > AXIS_W'(MAX_AXIS_BITS)) ? AXIS_W'(MAX_AXIS_BITS) : v;
	endfunction

	function automatic logic [COORD_W-1:0] low_mask(logic [AXIS_W-1:0] n);
		logic [COORD_W:0] m;
		m = ((COORD_W+1)'(1) << n) - (COORD_W+1)'(1);
		return m[COORD_W-1:0];
	endfunction

	function automatic logic [COORD_W-1:0] gray_to_bin(logic [COORD_W-1:0] g);
		logic [COORD_W-1:0] b;
		b = g;
		b = b ^ (b >> 8);
		b = b ^ (b >> 4);
		b = b ^ (b >> 2);
		b = b ^ (b >> 1);
		return b;
	endfunction

endpackage
`default_nettype wire

// ===== design/bgc_front.sv =====
`default_nettype none
module bgc_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire bgc_pkg::cfg_t                       cfg,
	input  wire logic                                push,
	output logic                                     full,
	input  wire logic [bgc_pkg::SAMPLE_BITS-1:0]     sample_normal,
	input  wire logic [bgc_pkg::SAMPLE_BITS-1:0]     sample_inverted,
	input  wire logic                                last_pair,
	input  wire logic                                job_full,
	output logic                                     job_push,
	output bgc_pkg::job_t                            job
);

	logic [bgc_pkg::CNT_W-1:0]       cnt_q;
	logic [bgc_pkg::CODE_W-1:0]      code_q;
	logic [bgc_pkg::SUM_W-1:0]       sum_q;

	logic                            accept;
	logic [bgc_pkg::AXIS_W-1:0]      bx;
	logic [bgc_pkg::AXIS_W-1:0]      by;
	logic [bgc_pkg::CNT_W-1:0]       total;
	logic                            in_use;
	logic                            gt;
	logic [bgc_pkg::SAMPLE_BITS-1:0] diff;
	logic [bgc_pkg::CODE_W-1:0]      code_nxt;
	logic [bgc_pkg::SUM_W-1:0]       sum_nxt;
	logic [bgc_pkg::CNT_W-1:0]       cnt_nxt;

	assign full   = job_full;
	assign accept = push && !job_full;

	assign bx     = bgc_pkg::axis_bits(cfg.bits_x);
	assign by     = bgc_pkg::axis_bits(cfg.bits_y);
	assign total  = bgc_pkg::CNT_W'(bx) + bgc_pkg::CNT_W'(by);
	assign in_use = cnt_q < total;
	assign gt     = sample_normal > sample_inverted;
	assign diff   = gt ? (sample_normal - sample_inverted) : (sample_inverted - sample_normal);

	always_comb begin
		code_nxt = code_q;
		sum_nxt  = sum_q;
		if (in_use) begin
			if (gt) begin
				code_nxt = code_q | (bgc_pkg::CODE_W'(1) << cnt_q[4:0]);
			end
			sum_nxt = sum_q + bgc_pkg::SUM_W'(diff);
		end
		cnt_nxt = (cnt_q < bgc_pkg::CNT_MAX) ? (cnt_q + bgc_pkg::CNT_W'(1)) : cnt_q;
	end

	assign job_push   = accept && last_pair;
	assign job.code   = code_nxt;
	assign job.sum    = sum_nxt;
	assign job.used   = (cnt_nxt < total) ? cnt_nxt : total;
	assign job.wrong  = cnt_nxt != total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			code_q <= '0;
			sum_q  <= '0;
		end else if (accept) begin
			if (last_pair) begin
				cnt_q  <= '0;
				code_q <= '0;
				sum_q  <= '0;
			end else begin
				cnt_q  <= cnt_nxt;
				code_q <= code_nxt;
				sum_q  <= sum_nxt;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/bgc_fifo.sv =====
`default_nettype none
module bgc_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire bgc_pkg::job_t wr_data,
	output logic               full,
	input  wire logic          rd_en,
	output bgc_pkg::job_t      rd_data,
	output logic               empty
);

	bgc_pkg::job_t                 mem_q [bgc_pkg::FIFO_DEPTH];
	logic [bgc_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [bgc_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [bgc_pkg::FIFO_PTR_W:0]   count_q;
	logic                           do_wr;
	logic                           do_rd;

	assign full    = count_q == (bgc_pkg::FIFO_PTR_W+1)'(bgc_pkg::FIFO_DEPTH);
	assign empty   = count_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + bgc_pkg::FIFO_PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + bgc_pkg::FIFO_PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (bgc_pkg::FIFO_PTR_W+1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (bgc_pkg::FIFO_PTR_W+1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/bgc_back.sv =====
`default_nettype none
`include "balanced_gray_code_pixel_decoder_assert.svh"
module bgc_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire bgc_pkg::cfg_t                  cfg,
	input  wire logic                           job_empty,
	input  wire bgc_pkg::job_t                  job,
	output logic                                job_pop,
	output logic                                empty,
	input  wire logic                           pop,
	output logic [bgc_pkg::IDX_W-1:0]           projector_index,
	output logic [bgc_pkg::MEAN_W-1:0]          mean_distance,
	output logic                                code_unmapped,
	output logic                                pair_count_wrong
);

	bgc_pkg::state_t                 state_q;
	bgc_pkg::state_t                 state_nxt;
	bgc_pkg::job_t                   job_q;
	logic [bgc_pkg::COORD_W-1:0]     x_q;
	logic [bgc_pkg::COORD_W-1:0]     y_q;
	logic [bgc_pkg::PROD_W-1:0]      prod_q;
	logic                            unmapped_q;
	logic [bgc_pkg::SUM_W-1:0]       dvd_q;
	logic [bgc_pkg::CNT_W-1:0]       rem_q;
	logic [bgc_pkg::DIV_CNT_W-1:0]   div_cnt_q;
	logic                            out_valid_q;

	logic                            out_load;
	logic                            div_done;
	logic [bgc_pkg::AXIS_W-1:0]      bx;
	logic [bgc_pkg::AXIS_W-1:0]      by;
	logic [bgc_pkg::CODE_W-1:0]      y_shift;
	logic [bgc_pkg::CNT_W:0]         trial;
	logic                            trial_ge;
	logic [bgc_pkg::CNT_W:0]         trial_sub;
	logic [bgc_pkg::PROD_W-1:0]      idx_sum;

	assign bx      = bgc_pkg::axis_bits(cfg.bits_x);
	assign by      = bgc_pkg::axis_bits(cfg.bits_y);
	assign y_shift = job_q.code >> bx;

	assign trial     = {rem_q, dvd_q[bgc_pkg::SUM_W-1]};
	assign trial_ge  = trial >= {1'b0, job_q.used};
	assign trial_sub = trial - {1'b0, job_q.used};
	assign div_done  = div_cnt_q == bgc_pkg::DIV_LAST;
	assign idx_sum   = prod_q + bgc_pkg::PROD_W'(x_q);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			bgc_pkg::ST_IDLE: begin
				if (!job_empty) state_nxt = bgc_pkg::ST_DECODE;
			end
			bgc_pkg::ST_DECODE: state_nxt = bgc_pkg::ST_MULT;
			bgc_pkg::ST_MULT:   state_nxt = bgc_pkg::ST_DIV;
			bgc_pkg::ST_DIV: begin
				if (div_done) state_nxt = bgc_pkg::ST_FINISH;
			end
			bgc_pkg::ST_FINISH: begin
				if (!out_valid_q || pop) state_nxt = bgc_pkg::ST_IDLE;
			end
			default: state_nxt = bgc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		job_pop  = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			bgc_pkg::ST_IDLE:   job_pop  = !job_empty;
			bgc_pkg::ST_FINISH: out_load = !out_valid_q || pop;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bgc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
		end
		unique case (state_q)
			bgc_pkg::ST_DECODE: begin
				x_q <= bgc_pkg::gray_to_bin(job_q.code[bgc_pkg::COORD_W-1:0] &
					bgc_pkg::low_mask(bx));
				y_q <= bgc_pkg::gray_to_bin(y_shift[bgc_pkg::COORD_W-1:0] &
					bgc_pkg::low_mask(by));
			end
			bgc_pkg::ST_MULT: begin
				prod_q     <= y_q * cfg.width;
				unmapped_q <= ({1'b0, x_q} >= cfg.width) || ({1'b0, y_q} >= cfg.height);
				dvd_q      <= job_q.sum;
				rem_q      <= '0;
				div_cnt_q  <= '0;
			end
			bgc_pkg::ST_DIV: begin
				rem_q     <= trial_ge ? trial_sub[bgc_pkg::CNT_W-1:0] : trial[bgc_pkg::CNT_W-1:0];
				dvd_q     <= {dvd_q[bgc_pkg::SUM_W-2:0], trial_ge};
				div_cnt_q <= div_cnt_q + bgc_pkg::DIV_CNT_W'(1);
			end
			default: ;
		endcase
		if (out_load) begin
			projector_index  <= unmapped_q ? '0 : idx_sum[bgc_pkg::IDX_W-1:0];
			mean_distance    <= (job_q.used == '0) ? '0 : dvd_q[bgc_pkg::MEAN_W-1:0];
			code_unmapped    <= unmapped_q;
			pair_count_wrong <= job_q.wrong;
		end
	end

	assign empty = !out_valid_q;

	`BGC_ASSERT(a_decode_after_pop, clk, arst_n, (state_q == bgc_pkg::ST_DECODE) |-> $past(job_pop), "decode without a queued job")
	`BGC_ASSERT(a_finish_after_div, clk, arst_n, ((state_q == bgc_pkg::ST_FINISH) && ($past(state_q) != bgc_pkg::ST_FINISH)) |-> (($past(state_q) == bgc_pkg::ST_DIV) && ($past(div_cnt_q) == bgc_pkg::DIV_LAST)), "divider cut short")
	`BGC_ASSERT_NEVER(a_rem_bound, clk, arst_n, (state_q == bgc_pkg::ST_FINISH) && (job_q.used != '0) && (rem_q >= job_q.used), "remainder not below divisor")

endmodule
`default_nettype wire

// ===== design/balanced_gray_code_pixel_decoder.sv =====
// Structured-light pixel decoder. Each push beat carries one frame pair (normal and inverted
// sample) of one camera pixel; last_pair closes the pixel. Pairs are taken one per clock
// while full is low. A closed pixel is queued (two deep) and then decoded: it is fetched,
// Gray decoded, put through the y*width multiply and the bit-serial mean divider, and then
// loaded into the output register once that register is free. Pairs of the next pixel are
// taken meanwhile; full rises only while the pixel queue holds two closed pixels. The result
// (projector index, mean distance, unmapped and pair-count flags) waits in the output
// register until popped. Configuration writes are always ready and must be done idle.
`default_nettype none
module balanced_gray_code_pixel_decoder (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [bgc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [bgc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                               push,
	output logic                                    full,
	input  wire logic [bgc_pkg::SAMPLE_BITS-1:0]    sample_normal,
	input  wire logic [bgc_pkg::SAMPLE_BITS-1:0]    sample_inverted,
	input  wire logic                               last_pair,
	output logic                                    empty,
	input  wire logic                               pop,
	output logic [bgc_pkg::IDX_W-1:0]               projector_index,
	output logic [bgc_pkg::MEAN_W-1:0]              mean_distance,
	output logic                                    code_unmapped,
	output logic                                    pair_count_wrong
);

	bgc_pkg::cfg_t cfg_q;
	bgc_pkg::job_t front_job;
	bgc_pkg::job_t head_job;
	logic          front_push;
	logic          job_full;
	logic          job_empty;
	logic          job_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bits_x <= bgc_pkg::AXIS_W'(10);
			cfg_q.bits_y <= bgc_pkg::AXIS_W'(10);
			cfg_q.width  <= bgc_pkg::DIM_W'(1024);
			cfg_q.height <= bgc_pkg::DIM_W'(768);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bgc_pkg::CFG_BITS_X:      cfg_q.bits_x <= cfg_data[bgc_pkg::AXIS_W-1:0];
				bgc_pkg::CFG_BITS_Y:      cfg_q.bits_y <= cfg_data[bgc_pkg::AXIS_W-1:0];
				bgc_pkg::CFG_PROJ_WIDTH:  cfg_q.width  <= cfg_data[bgc_pkg::DIM_W-1:0];
				bgc_pkg::CFG_PROJ_HEIGHT: cfg_q.height <= cfg_data[bgc_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	bgc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.push            (push),
		.full            (full),
		.sample_normal   (sample_normal),
		.sample_inverted (sample_inverted),
		.last_pair       (last_pair),
		.job_full        (job_full),
		.job_push        (front_push),
		.job             (front_job)
	);

	bgc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_push),
		.wr_data (front_job),
		.full    (job_full),
		.rd_en   (job_pop),
		.rd_data (head_job),
		.empty   (job_empty)
	);

	bgc_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.job_empty        (job_empty),
		.job              (head_job),
		.job_pop          (job_pop),
		.empty            (empty),
		.pop              (pop),
		.projector_index  (projector_index),
		.mean_distance    (mean_distance),
		.code_unmapped    (code_unmapped),
		.pair_count_wrong (pair_count_wrong)
	);

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;

	class pixel_scoreboard;
		typedef struct packed {
			logic [31:0] index;
			logic [7:0]  mean;
			logic        unmapped;
			logic        count_wrong;
		} pixel_result_t;

		logic [4:0]  bits_x = 5'd10;
		logic [4:0]  bits_y = 5'd10;
		logic [16:0] width  = 17'd1024;
		logic [16:0] height = 17'd768;

		logic [5:0]  pairs_seen = '0;
		logic [31:0] code       = '0;
		logic [13:0] diff_sum   = '0;

		pixel_result_t pending_pixels[$];
		int failures = 0;

		function int axis_eff(logic [4:0] v);
			return (v > 5'd16) ? 16 : int'(v);
		endfunction

		function int pair_total();
			return axis_eff(bits_x) + axis_eff(bits_y);
		endfunction

		function logic [31:0] ones(int n);
			return (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
		endfunction

		function logic [31:0] gray_decode(logic [31:0] g);
			logic [31:0] b;
			b[31] = g[31];
			for (int i = 30; i >= 0; i--)
				b[i] = b[i+1] ^ g[i];
			return b;
		endfunction

		function void set_reg(logic [2:0] idx, logic [16:0] data);
			case (idx)
				bgc_pkg::CFG_BITS_X:      bits_x = data[4:0];
				bgc_pkg::CFG_BITS_Y:      bits_y = data[4:0];
				bgc_pkg::CFG_PROJ_WIDTH:  width  = data;
				bgc_pkg::CFG_PROJ_HEIGHT: height = data;
				default: ;
			endcase
		endfunction

		function void note_pair(logic [7:0] a, logic [7:0] b, logic lp);
			int total;
			int used;
			int bxe;
			int bye;
			logic [31:0] xc;
			logic [31:0] yc;
			logic [63:0] prod;
			pixel_result_t r;
			total = pair_total();
			bxe = axis_eff(bits_x);
			bye = axis_eff(bits_y);
			if (int'(pairs_seen) < total) begin
				if (a > b)
					code[pairs_seen] = 1'b1;
				diff_sum = diff_sum + ((a > b) ? a - b : b - a);
			end
			if (pairs_seen != 6'h3F)
				pairs_seen++;
			if (!lp)
				return;
			used = (int'(pairs_seen) < total) ? int'(pairs_seen) : total;
			xc = gray_decode(code & ones(bxe));
			yc = gray_decode((code >> bxe) & ones(bye));
			r.unmapped = (xc >= 32'(width)) || (yc >= 32'(height));
			prod = 64'(yc) * 64'(width) + 64'(xc);
			r.index = r.unmapped ? 32'd0 : prod[31:0];
			r.mean = (used == 0) ? 8'd0 : 8'(int'(diff_sum) / used);
			r.count_wrong = (int'(pairs_seen) != total);
			pending_pixels.push_back(r);
			pairs_seen = '0;
			code = '0;
			diff_sum = '0;
		endfunction

		function void check_pixel(logic [31:0] idx, logic [7:0] mean, logic unm, logic wrong);
			pixel_result_t e;
			if (pending_pixels.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: unexpected result idx %0d mean %0d", $realtime, idx, mean);
				return;
			end
			e = pending_pixels.pop_front();
			if (e.index !== idx || e.mean !== mean || e.unmapped !== unm
					|| e.count_wrong !== wrong) begin
				failures++;
				if (failures <= 10)
					$display("%0t: mismatch exp idx %0d mean %0d unm %0b wrong %0b, got idx %0d mean %0d unm %0b wrong %0b",
						$realtime, e.index, e.mean, e.unmapped, e.count_wrong,
						idx, mean, unm, wrong);
			end
		endfunction

		function int pending();
			return pending_pixels.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [bgc_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [bgc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
	logic        push = 1'b0;
	logic        full;
	logic [bgc_pkg::SAMPLE_BITS-1:0] sample_normal = '0;
	logic [bgc_pkg::SAMPLE_BITS-1:0] sample_inverted = '0;
	logic        last_pair = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [bgc_pkg::IDX_W-1:0]       projector_index;
	logic [bgc_pkg::MEAN_W-1:0]      mean_distance;
	logic        code_unmapped;
	logic        pair_count_wrong;

	pixel_scoreboard sb = new();
	bit quiet = 1'b0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int stall_cycles = 0;

	balanced_gray_code_pixel_decoder dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// beat monitor: samples pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.set_reg(cfg_index, cfg_data);
			if (push && !full)
				sb.note_pair(sample_normal, sample_inverted, last_pair);
			if (pop && !empty)
				sb.check_pixel(projector_index, mean_distance, code_unmapped,
					pair_count_wrong);
			if ((cfg_valid && cfg_ready) || (push && !full) || (pop && !empty))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= quiet || ($urandom_range(0, 99) >= 29);
		end
	end

	task automatic send_pair(input logic [7:0] a, input logic [7:0] b, input logic lp);
		while (!quiet && $urandom_range(0, 99) < 29) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		sample_normal <= a;
		sample_inverted <= b;
		last_pair <= lp;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic drain(input int tail);
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [16:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic program_axes(input int bx, input int by, input int w, input int h);
		write_reg(bgc_pkg::CFG_BITS_X, {12'($urandom), 5'(bx)});
		write_reg(bgc_pkg::CFG_BITS_Y, {12'($urandom), 5'(by)});
		write_reg(bgc_pkg::CFG_PROJ_WIDTH, 17'(w));
		write_reg(bgc_pkg::CFG_PROJ_HEIGHT, 17'(h));
		// unused register slot, must be ignored
		write_reg(3'($urandom_range(4, 7)), 17'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// mostly well-formed pixels, some short, some long, a few overflowing the counter
	task automatic run_pixels(input int budget);
		int sent;
		int n;
		int kind;
		int total;
		logic [7:0] a;
		logic [7:0] b;
		sent = 0;
		while (sent < budget) begin
			total = sb.pair_total();
			kind = $urandom_range(0, 99);
			if (kind < 75)
				n = (total == 0) ? 1 : total;
			else if (kind < 87)
				n = $urandom_range(1, (total > 1) ? total - 1 : 1);
			else if (kind < 97)
				n = total + $urandom_range(1, 5);
			else
				n = $urandom_range(60, 70);
			for (int i = 1; i <= n; i++) begin
				a = 8'($urandom_range(0, 255));
				b = ($urandom_range(0, 99) < 12) ? a : 8'($urandom_range(0, 255));
				send_pair(a, b, i == n);
			end
			sent += n;
		end
	endtask

	initial begin
		int bx;
		int by;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pair(8'd255, 8'd0, 1'b1);
		send_pair(8'd0, 8'd255, 1'b1);
		send_pair(8'd128, 8'd128, 1'b1);
		for (int i = 1; i <= 20; i++)
			send_pair(8'd255, 8'd0, i == 20);
		run_pixels(80);

		drain(30);
		program_axes(1, 1, 2, 2);
		run_pixels(100);

		drain(30);
		program_axes(16, 16, 65536, 65536);
		run_pixels(60);
		hold_req = 1'b1;
		run_pixels(60);

		drain(30);
		program_axes(0, 3, 1, 8);
		run_pixels(100);

		drain(30);
		program_axes(31, 20, 0, 65536);
		run_pixels(50);
		drain(0);
		run_pixels(50);

		drain(30);
		program_axes(4, 0, 10, 1);
		quiet = 1'b1;
		run_pixels(100);
		quiet = 1'b0;

		drain(30);
		program_axes(0, 0, 1, 1);
		run_pixels(100);

		drain(30);
		program_axes(5, 6, 131071, 131071);
		run_pixels(100);

		drain(30);
		program_axes(7, 9, 100, 0);
		run_pixels(100);

		repeat (2) begin
			drain(30);
			bx = $urandom_range(0, 18);
			by = $urandom_range(0, 18);
			program_axes(bx, by,
				$urandom_range(1, 1 << ((bx > 16) ? 16 : bx)),
				$urandom_range(1, 1 << ((by > 16) ? 16 : by)));
			run_pixels(100);
		end

		drain(40);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
